// File: rtl/core/pfa_pkg.sv
// Shared types, constants and codes for the page frame allocator.
// No dependencies; pfa_fresh and page_frame_allocator in rtl/core refer to this package by scope.
package pfa_pkg;

  localparam int StackDepth   = 128;
  localparam int PrefillPages = 100;
  localparam int PageBytes    = 4096;
  localparam int PageShift    = $clog2(PageBytes);
  localparam int MaxRegions   = 3;

  localparam int AddrW      = 52;
  localparam int PageNumW   = AddrW - PageShift;
  localparam int AllocW     = 40;
  localparam int FreeCountW = 8;
  localparam int CfgIdxW    = 3;
  localparam int RegionW    = 2;
  localparam int CountW     = $clog2(StackDepth + 1);
  localparam int StackAw    = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int FillLimit  = (PrefillPages < StackDepth) ? PrefillPages : StackDepth;

  typedef logic [CountW-1:0]     count_t;
  typedef logic [StackAw-1:0]    stack_addr_t;
  typedef logic [FreeCountW-1:0] fcount_t;
  typedef logic [AddrW-1:0]      addr_t;
  typedef logic [AddrW:0]        addr_ext_t;   // one carry bit above the address space
  typedef logic [PageNumW-1:0]   page_num_t;
  typedef logic [RegionW-1:0]    region_t;

  localparam count_t DepthCount = count_t'(StackDepth);
  localparam count_t FillCount  = count_t'(FillLimit);

  // item kinds
  localparam logic [1:0] KIND_INIT  = 2'd0;
  localparam logic [1:0] KIND_ALLOC = 2'd1;
  localparam logic [1:0] KIND_FREE  = 2'd2;

  // result status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OOM  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_REGION_COUNT = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_R0_BASE      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_R0_LEN       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_R1_BASE      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_R1_LEN       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_R2_BASE      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_R2_LEN       = 3'd6;

  typedef struct packed {
    logic [1:0] kind;
    addr_t      page_addr;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    addr_t             granted_addr;
    fcount_t           free_count;
    logic [AllocW-1:0] alloc_count;
  } rsp_t;

  typedef struct packed {
    logic rewind;
    logic next;
  } fresh_cmd_t;

  typedef struct packed {
    logic  done;
    logic  ok;
    addr_t page;
  } fresh_rsp_t;

endpackage

// File: rtl/core/pfa_stack_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the free page stack; no dependencies.
module pfa_stack_ram #(
  parameter int Depth = 128,
  parameter int Width = 40
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                           rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/pfa_fresh.sv
// Fresh page source: region registers, bump pointer and region walk.
// Depends on pfa_pkg. One region test per cycle; done pulses for one cycle.
module pfa_fresh (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pfa_pkg::CfgIdxW-1:0]         cfg_index,
  input  pfa_pkg::addr_t                      cfg_data,
  input  pfa_pkg::fresh_cmd_t                 cmd,
  output pfa_pkg::fresh_rsp_t                 rsp
);

  typedef enum logic {
    FR_IDLE,
    FR_TEST
  } fr_state_t;

  fr_state_t                  state;
  pfa_pkg::region_t           region_count;
  pfa_pkg::addr_t             base [3];
  pfa_pkg::addr_t             len  [3];
  pfa_pkg::addr_ext_t         region_end [3];
  pfa_pkg::addr_t             bump;
  pfa_pkg::region_t           ri;
  pfa_pkg::addr_ext_t         p;

  pfa_pkg::region_t           n_eff;
  pfa_pkg::region_t           ri_inc;
  pfa_pkg::addr_ext_t         cur_end;
  pfa_pkg::addr_t             next_base;
  pfa_pkg::addr_ext_t         p_top;
  logic [pfa_pkg::PageNumW:0] skip_pn;
  pfa_pkg::addr_ext_t         skip_addr;
  pfa_pkg::addr_ext_t         end_sum [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= pfa_pkg::region_t'(1);
      for (int r = 0; r < 3; r++) begin
        base[r] <= '0;
        len[r]  <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        pfa_pkg::REG_REGION_COUNT: region_count <= cfg_data[pfa_pkg::RegionW-1:0];
        pfa_pkg::REG_R0_BASE:      base[0] <= cfg_data;
        pfa_pkg::REG_R0_LEN:       len[0]  <= cfg_data;
        pfa_pkg::REG_R1_BASE:      base[1] <= cfg_data;
        pfa_pkg::REG_R1_LEN:       len[1]  <= cfg_data;
        pfa_pkg::REG_R2_BASE:      base[2] <= cfg_data;
        pfa_pkg::REG_R2_LEN:       len[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // region end, clamped to the top of the address space, kept registered
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      end_sum[r] = {1'b0, base[r]} + {1'b0, len[r]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        region_end[r] <= '0;
      end
    end else begin
      for (int r = 0; r < 3; r++) begin
        region_end[r] <= end_sum[r][pfa_pkg::AddrW] ?
                         {1'b1, {pfa_pkg::AddrW{1'b0}}} : end_sum[r];
      end
    end
  end

  always_comb begin
    if (region_count == '0) begin
      n_eff = pfa_pkg::region_t'(1);
    end else if (region_count > pfa_pkg::region_t'(pfa_pkg::MaxRegions)) begin
      n_eff = pfa_pkg::region_t'(pfa_pkg::MaxRegions);
    end else begin
      n_eff = region_count;
    end
    ri_inc = ri + pfa_pkg::region_t'(1);
    unique case (ri)
      2'd0:    cur_end = region_end[0];
      2'd1:    cur_end = region_end[1];
      default: cur_end = region_end[2];
    endcase
    unique case (ri_inc)
      2'd1:    next_base = base[1];
      default: next_base = base[2];
    endcase
    p_top     = p + pfa_pkg::addr_ext_t'(pfa_pkg::PageBytes);
    // first page boundary strictly above the next region's base
    skip_pn   = {1'b0, next_base[pfa_pkg::AddrW-1:pfa_pkg::PageShift]} +
                (pfa_pkg::PageNumW + 1)'(1);
    skip_addr = {skip_pn, {pfa_pkg::PageShift{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= FR_IDLE;
      bump     <= '0;
      ri       <= '0;
      rsp.done <= 1'b0;
      rsp.ok   <= 1'b0;
      rsp.page <= '0;
    end else begin
      unique case (state)
        FR_IDLE: begin
          rsp.done <= !cmd.rewind && cmd.next && (ri >= n_eff);
          if (cmd.rewind) begin
            bump <= base[0];
            ri   <= '0;
          end else if (cmd.next) begin
            if (ri >= n_eff) begin
              rsp.ok   <= 1'b0;
              rsp.page <= '0;
            end else begin
              p     <= {1'b0, bump} + pfa_pkg::addr_ext_t'(pfa_pkg::PageBytes);
              state <= FR_TEST;
            end
          end
        end
        FR_TEST: begin
          rsp.done <= (p_top <= cur_end) || (ri_inc >= n_eff);
          if (p_top > cur_end) begin
            ri <= ri_inc;
            if (ri_inc >= n_eff) begin
              bump     <= p[pfa_pkg::AddrW-1:0];
              rsp.ok   <= 1'b0;
              rsp.page <= '0;
              state    <= FR_IDLE;
            end else begin
              p <= skip_addr;
            end
          end else begin
            bump     <= p[pfa_pkg::AddrW-1:0];
            rsp.ok   <= 1'b1;
            rsp.page <= p[pfa_pkg::AddrW-1:0];
            state    <= FR_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/core/page_frame_allocator.sv
// Page frame allocator top: item sequencer, free stack RAM and fresh page source.
// Depends on pfa_pkg, pfa_stack_ram and pfa_fresh.
//
// Flow: a free or unknown word goes from S_EXEC to S_OUT; an alloc served from
// the free stack reads the stack RAM in S_EXEC and takes the registered read
// data in S_POP; an alloc from the bump pointer waits in S_ALLOC_WAIT while the
// fresh page source walks the regions, also once the pool is exhausted. An init
// does one region test and one stack write per page pushed, plus a test per
// region skipped, up to a full prefill of 100 pages. The
// next word is accepted while a result waits in the output register; results
// leave in item order. No clearing pass runs after reset.
module page_frame_allocator (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  pfa_pkg::req_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output pfa_pkg::rsp_t               rsp,
  input  logic                        cfg_we,
  input  logic [pfa_pkg::CfgIdxW-1:0] cfg_index,
  input  pfa_pkg::addr_t              cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_INIT,
    S_INIT_WAIT,
    S_POP,
    S_ALLOC_WAIT,
    S_OUT
  } state_t;

  state_t                        state;
  logic [1:0]                    kind_q;
  pfa_pkg::addr_t                addr_q;
  pfa_pkg::count_t               count;
  pfa_pkg::count_t               count_m1;
  logic [pfa_pkg::AllocW-1:0]    allocated;
  logic [1:0]                    res_status;
  pfa_pkg::addr_t                res_granted;

  logic                          out_free;
  logic                          ram_we;
  logic                          ram_re;
  pfa_pkg::stack_addr_t          ram_waddr;
  pfa_pkg::stack_addr_t          ram_raddr;
  pfa_pkg::page_num_t            ram_wdata;
  pfa_pkg::page_num_t            ram_rdata;
  pfa_pkg::fresh_cmd_t           fresh_cmd;
  pfa_pkg::fresh_rsp_t           fresh_rsp;

  pfa_stack_ram #(
    .Depth (pfa_pkg::StackDepth),
    .Width (pfa_pkg::PageNumW)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfa_fresh u_fresh (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (fresh_cmd),
    .rsp       (fresh_rsp)
  );

  assign out_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) || ((state == S_OUT) && out_free);
  assign count_m1  = count - pfa_pkg::count_t'(1);

  // Stack writes and reads land in different items' cycles, so a pop always
  // sees the entry pushed earlier without forwarding.
  always_comb begin
    ram_we = ((state == S_EXEC) && (kind_q == pfa_pkg::KIND_FREE) &&
              (count < pfa_pkg::DepthCount)) ||
             ((state == S_INIT_WAIT) && fresh_rsp.done && fresh_rsp.ok);
    ram_waddr = count[pfa_pkg::StackAw-1:0];
    ram_wdata = (state == S_EXEC) ? addr_q[pfa_pkg::AddrW-1:pfa_pkg::PageShift]
                                  : fresh_rsp.page[pfa_pkg::AddrW-1:pfa_pkg::PageShift];
    ram_re    = (state == S_EXEC) && (kind_q == pfa_pkg::KIND_ALLOC) && (count != '0);
    ram_raddr = count_m1[pfa_pkg::StackAw-1:0];
    fresh_cmd.rewind = (state == S_EXEC) && (kind_q == pfa_pkg::KIND_INIT);
    fresh_cmd.next   = ((state == S_EXEC) && (kind_q == pfa_pkg::KIND_ALLOC) &&
                        (count == '0)) ||
                       ((state == S_INIT) && (count < pfa_pkg::FillCount));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      allocated <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (rsp_valid && rsp_ready && (state != S_OUT)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            kind_q <= req.kind;
            addr_q <= req.page_addr;
            state  <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_status  <= ((kind_q == pfa_pkg::KIND_FREE) &&
                          (count >= pfa_pkg::DepthCount)) ? pfa_pkg::ST_FULL
                                                          : pfa_pkg::ST_OK;
          res_granted <= '0;
          unique case (kind_q)
            pfa_pkg::KIND_INIT: begin
              state <= S_INIT;
            end
            pfa_pkg::KIND_ALLOC: begin
              if (count != '0) begin
                count <= count_m1;
                state <= S_POP;
              end else begin
                state <= S_ALLOC_WAIT;
              end
            end
            pfa_pkg::KIND_FREE: begin
              if (count < pfa_pkg::DepthCount) begin
                count <= count + pfa_pkg::count_t'(1);
              end
              if (allocated != '0) begin
                allocated <= allocated - (pfa_pkg::AllocW)'(1);
              end
              state <= S_OUT;
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_INIT: begin
          if (count < pfa_pkg::FillCount) begin
            state <= S_INIT_WAIT;
          end else begin
            state <= S_OUT;
          end
        end
        S_INIT_WAIT: begin
          if (fresh_rsp.done) begin
            if (fresh_rsp.ok) begin
              count <= count + pfa_pkg::count_t'(1);
              state <= S_INIT;
            end else begin
              res_status <= pfa_pkg::ST_OOM;
              state      <= S_OUT;
            end
          end
        end
        S_POP: begin
          res_granted <= {ram_rdata, {pfa_pkg::PageShift{1'b0}}};
          if (allocated != '1) begin
            allocated <= allocated + (pfa_pkg::AllocW)'(1);
          end
          state <= S_OUT;
        end
        S_ALLOC_WAIT: begin
          if (fresh_rsp.done) begin
            if (fresh_rsp.ok) begin
              res_granted <= fresh_rsp.page;
              if (allocated != '1) begin
                allocated <= allocated + (pfa_pkg::AllocW)'(1);
              end
            end else begin
              res_status <= pfa_pkg::ST_OOM;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            rsp.status       <= res_status;
            rsp.granted_addr <= res_granted;
            rsp.free_count   <= pfa_pkg::fcount_t'(count);
            rsp.alloc_count  <= allocated;
            rsp_valid        <= 1'b1;
            if (req_valid) begin
              kind_q <= req.kind;
              addr_q <= req.page_addr;
              state  <= S_EXEC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pfa_pkg::DepthCount)
    else $error("free stack count above depth");

  a_ram_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("stack read and write in the same cycle");

  a_fresh_done_wait: assert property (@(posedge clk) disable iff (rst)
    fresh_rsp.done |-> (state == S_INIT_WAIT || state == S_ALLOC_WAIT))
    else $error("fresh page result with no one waiting");

  a_pop_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> $past(ram_re))
    else $error("pop result without a stack read");

endmodule

// File: tb/tb.sv
// Self-checking bench for page_frame_allocator: init, alloc, free and unused words
// against an in-bench free stack and bump pointer model. Depends on pfa_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
  import pfa_pkg::*;

  typedef logic [63:0] wide_t;

  localparam logic [1:0] KindUnused  = 2'd3;
  localparam wide_t      AddrTop     = 64'd1 << AddrW;
  localparam addr_t      AddrAllOnes = '1;
  localparam int         HoldCycles  = 300;
  localparam int         DrainCycles = 12;
  localparam int         CycleLimit  = 1000000;
  localparam int         PhaseWords  = 240;

  logic              clk;
  logic              rst;
  logic              req_valid;
  logic              req_ready;
  req_t              req;
  logic              rsp_valid;
  logic              rsp_ready;
  rsp_t              rsp;
  logic              cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  addr_t             cfg_data;

  page_frame_allocator dut (
    .clk, .rst, .req_valid, .req_ready, .req, .rsp_valid, .rsp_ready, .rsp,
    .cfg_we, .cfg_index, .cfg_data
  );

  // allocator model state
  logic [1:0]        rg_count;
  addr_t             rg_base [MaxRegions];
  addr_t             rg_len  [MaxRegions];
  page_num_t         m_stack [StackDepth];
  count_t            m_depth;
  addr_t             m_bump;
  region_t           m_region;
  logic [AllocW-1:0] m_alloc;

  rsp_t  due_results [$];
  addr_t handed_out [$];
  rsp_t  want_rsp;

  bit idle_on = 1'b1;
  bit hold_go = 1'b0;
  int cycle_count = 0;
  int fails = 0;
  int words_sent = 0, words_checked = 0;
  int n_init = 0, n_alloc = 0, n_free = 0, n_unused = 0, n_oom = 0, n_drop = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             due_results.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------- model
  function automatic int usable_regions();
    int n = rg_count;
    if (n == 0) n = 1;
    if (n > MaxRegions) n = MaxRegions;
    return n;
  endfunction

  function automatic wide_t region_limit(int r);
    wide_t e = wide_t'(rg_base[r]) + wide_t'(rg_len[r]);
    if (e > AddrTop) e = AddrTop;
    return e;
  endfunction

  // next page from the bump pointer, walking on to later regions as needed
  function automatic bit fresh_page(output wide_t page);
    int    n = usable_regions();
    wide_t p;
    wide_t b;
    page = '0;
    if (m_region >= n) return 1'b0;
    p = wide_t'(m_bump) + PageBytes;
    while (p + PageBytes > region_limit(m_region)) begin
      m_region++;
      if (m_region >= n) begin
        m_bump = addr_t'(p);
        return 1'b0;
      end
      b = wide_t'(rg_base[m_region]);
      p = b + PageBytes - (b % PageBytes);
    end
    m_bump = addr_t'(p);
    page = wide_t'(m_bump);
    return 1'b1;
  endfunction

  function automatic rsp_t frame_result(req_t w);
    rsp_t  r;
    wide_t page;
    bit    got;
    bit    ran_out;
    r = '0;
    case (w.kind)
      KIND_INIT: begin
        m_bump = rg_base[0];
        m_region = '0;
        ran_out = 1'b0;
        while (!ran_out && m_depth < FillCount) begin
          if (fresh_page(page)) begin
            m_stack[m_depth] = page_num_t'(page >> PageShift);
            m_depth++;
          end else begin
            ran_out = 1'b1;
          end
        end
        if (ran_out) r.status = ST_OOM;
      end
      KIND_ALLOC: begin
        if (m_depth != 0) begin
          m_depth--;
          page = wide_t'(m_stack[m_depth]) << PageShift;
          got = 1'b1;
        end else begin
          got = fresh_page(page);
        end
        if (got) begin
          r.granted_addr = addr_t'(page);
          if (m_alloc != '1) m_alloc++;
        end else begin
          r.status = ST_OOM;
        end
      end
      KIND_FREE: begin
        if (m_depth < DepthCount) begin
          m_stack[m_depth] = page_num_t'(w.page_addr >> PageShift);
          m_depth++;
        end else begin
          r.status = ST_FULL;
        end
        if (m_alloc != '0) m_alloc--;
      end
      default: ;
    endcase
    r.free_count  = fcount_t'(m_depth);
    r.alloc_count = m_alloc;
    return r;
  endfunction

  function automatic void model_config(logic [CfgIdxW-1:0] idx, addr_t val);
    case (idx)
      REG_REGION_COUNT: rg_count = val[1:0];
      REG_R0_BASE:      rg_base[0] = val;
      REG_R0_LEN:       rg_len[0]  = val;
      REG_R1_BASE:      rg_base[1] = val;
      REG_R1_LEN:       rg_len[1]  = val;
      REG_R2_BASE:      rg_base[2] = val;
      REG_R2_LEN:       rg_len[2]  = val;
      default: ;
    endcase
  endfunction

  function automatic void reset_model();
    rg_count = 2'd1;
    for (int i = 0; i < MaxRegions; i++) begin
      rg_base[i] = '0;
      rg_len[i]  = '0;
    end
    m_depth  = '0;
    m_bump   = '0;
    m_region = '0;
    m_alloc  = '0;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, logic [127:0] want, logic [127:0] got);
    fails++;
    if (fails <= 10)
      $display("mismatch on %s at result %0d: expected %0h, got %0h", what,
               words_checked, want, got);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      words_checked++;
      if (due_results.size() == 0) begin
        report_mismatch("unexpected word", '0, rsp);
      end else begin
        want_rsp = due_results.pop_front();
        if (rsp.status !== want_rsp.status)
          report_mismatch("status", want_rsp.status, rsp.status);
        if (rsp.granted_addr !== want_rsp.granted_addr)
          report_mismatch("granted_addr", want_rsp.granted_addr, rsp.granted_addr);
        if (rsp.free_count !== want_rsp.free_count)
          report_mismatch("free_count", want_rsp.free_count, rsp.free_count);
        if (rsp.alloc_count !== want_rsp.alloc_count)
          report_mismatch("alloc_count", want_rsp.alloc_count, rsp.alloc_count);
      end
    end
  end

  // result side: random stalls, or one long hold-off when asked
  initial begin
    rsp_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        rsp_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        rsp_ready <= !(idle_on && $urandom_range(0, 99) < 14);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic addr_t rand_addr();
    return addr_t'({$urandom, $urandom});
  endfunction

  task automatic send_word(logic [1:0] kind, addr_t addr);
    req_t w;
    rsp_t r;
    w.kind = kind;
    w.page_addr = addr;
    if (idle_on && $urandom_range(0, 99) < 14) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    r = frame_result(w);
    due_results.push_back(r);
    words_sent++;
    case (kind)
      KIND_INIT:  n_init++;
      KIND_ALLOC: n_alloc++;
      KIND_FREE:  n_free++;
      default:    n_unused++;
    endcase
    if (r.status == ST_OOM) n_oom++;
    if (r.status == ST_FULL) n_drop++;
    if (kind == KIND_ALLOC && r.status == ST_OK && handed_out.size() < 512)
      handed_out.push_back(r.granted_addr);
  endtask

  task automatic wait_for_results();
    if (req_valid) req_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, addr_t val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    model_config(idx, val);
  endtask

  // block must be idle here
  task automatic program_regions(addr_t cnt, addr_t b0, addr_t l0, addr_t b1, addr_t l1,
                                 addr_t b2, addr_t l2);
    write_reg(REG_REGION_COUNT, cnt);
    write_reg(REG_R0_BASE, b0);
    write_reg(REG_R0_LEN, l0);
    write_reg(REG_R1_BASE, b1);
    write_reg(REG_R1_LEN, l1);
    write_reg(REG_R2_BASE, b2);
    write_reg(REG_R2_LEN, l2);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_region(bit small_only, output addr_t base, output addr_t len);
    int mode = small_only ? 0 : $urandom_range(0, 3);
    case (mode)
      0: begin
        base = addr_t'($urandom_range(0, 1 << 20));
        len  = addr_t'($urandom_range(0, 40) * PageBytes + $urandom_range(0, 4095));
      end
      1: begin   // close under the top of the address space
        base = addr_t'(AddrTop - $urandom_range(1, 40) * PageBytes - $urandom_range(0, 4095));
        len  = ($urandom_range(0, 1) != 0) ? AddrAllOnes : rand_addr();
      end
      2: begin
        base = rand_addr();
        len  = rand_addr();
      end
      default: begin
        base = rand_addr();
        len  = '0;
      end
    endcase
  endtask

  task automatic program_random_regions(bit small_only);
    addr_t b [MaxRegions];
    addr_t l [MaxRegions];
    for (int i = 0; i < MaxRegions; i++) pick_region(small_only, b[i], l[i]);
    program_regions(addr_t'($urandom_range(0, 3)), b[0], l[0], b[1], l[1], b[2], l[2]);
  endtask

  // mostly pages handed out earlier, sometimes with junk in the offset bits
  function automatic addr_t free_target();
    int    idx;
    addr_t a;
    if (handed_out.size() != 0 && $urandom_range(0, 99) < 70) begin
      idx = $urandom_range(0, handed_out.size() - 1);
      a = handed_out[idx];
      handed_out.delete(idx);
      if ($urandom_range(0, 9) == 0) a[PageShift-1:0] = $urandom;
      return a;
    end
    return rand_addr();
  endfunction

  task automatic send_mixed(int n, int alloc_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2)                   send_word(KIND_INIT, rand_addr());
      else if (r < 4)              send_word(KindUnused, rand_addr());
      else if (r < 4 + alloc_pct)  send_word(KIND_ALLOC, rand_addr());
      else                         send_word(KIND_FREE, free_target());
    end
  endtask

  // ---------------------------------------------------------------- tests
  // reset registers: one region of zero length, so the pool starts exhausted
  task automatic test_reset_state();
    send_word(KIND_ALLOC, '0);
    send_word(KIND_FREE, '0);
    send_word(KindUnused, AddrAllOnes);
    send_word(KIND_ALLOC, AddrAllOnes);
  endtask

  // bump pointer skips into region 1, then to the last pages below 2^52
  task automatic test_region_walk();
    wait_for_results();
    program_regions(addr_t'(3), '0, '0, addr_t'('h5123), addr_t'('h100),
                    addr_t'(AddrTop - 2 * PageBytes - 5), AddrAllOnes);
    repeat (6) send_word(KIND_ALLOC, '0);
    send_word(KIND_INIT, AddrAllOnes);
    repeat (3) send_word(KIND_ALLOC, '0);
  endtask

  // region count zero reads as one; unaligned base; prefill stops short
  task automatic test_prefill();
    wait_for_results();
    program_regions('0, addr_t'('h100800), addr_t'('h30000), AddrAllOnes, AddrAllOnes,
                    AddrAllOnes, AddrAllOnes);
    send_word(KIND_INIT, '0);
    send_word(KIND_INIT, '0);
    send_word(KIND_ALLOC, '0);
    send_word(KIND_FREE, AddrAllOnes);
    send_word(KIND_FREE, addr_t'('h123));
    send_word(KIND_ALLOC, '0);
    send_word(KIND_ALLOC, '0);
  endtask

  // output held off while words keep coming, then a full pause mid-sequence
  task automatic test_backpressure();
    wait_for_results();
    program_regions(addr_t'(3), '0, AddrAllOnes, '0, '0, '0, '0);
    send_word(KIND_INIT, '0);
    idle_on = 1'b0;
    hold_go = 1'b1;
    send_mixed(40, 48);
    wait_for_results();
    idle_on = 1'b1;
    send_mixed(10, 48);
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      wait_for_results();
      idle_on = (ph != 3);
      program_random_regions(ph == 1);
      send_word(KIND_INIT, rand_addr());
      case (ph)
        1:       send_mixed(PhaseWords, 76);   // drain the pool
        2:       send_mixed(PhaseWords, 26);   // run the stack into its limit
        default: send_mixed(PhaseWords, 48);
      endcase
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst <= 1'b1;
    req_valid <= 1'b0;
    req <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    reset_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_region_walk();
    test_prefill();
    test_backpressure();
    test_random_phases();
    wait_for_results();

    $display("ran %0d words: %0d init, %0d alloc, %0d free, %0d unused kind", words_sent,
             n_init, n_alloc, n_free, n_unused);
    $display("%0d results checked, %0d out of memory, %0d dropped on full stack, %0d bad",
             words_checked, n_oom, n_drop, fails);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
